[rtl/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// pfa_pkg: shared definitions for the page-frame allocator
// Action and status codes, field widths and the types that travel between
// the sequencer and the shared find unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

   // Field widths of the request and response items
   localparam int ACTION_W    = 2;
   localparam int FRAME_W     = 10;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 8;
   localparam int CSR_W       = 11;
   localparam int CSR_IDX_W   = 1;

   // Width of one bitmap word and of a bit position inside it
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REL   = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOFREE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREE   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SAT    = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END   = 1'b1;

   // Query to the find unit: a vector and an inclusive window of positions
   typedef struct packed {
      logic [WORD_W-1:0] vec;
      logic [BIT_W-1:0]  lo;
      logic [BIT_W-1:0]  hi;
   } find_req_type;

   // Answer of the find unit: highest clear bit inside the window
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] pos;
   } find_res_type;

endpackage

[rtl/pfa_if.sv]
// ----------------------------------------------------------------------------
// pfa_if: request and response channels of the page-frame allocator
// Valid/ready channels; an item moves at a clock edge with both high.
// ----------------------------------------------------------------------------

// Request channel: action and frame index
interface pfa_req_if;
   logic                         valid;
   logic                         ready;
   logic [pfa_pkg::ACTION_W-1:0] action;
   logic [pfa_pkg::FRAME_W-1:0]  frame_index;

   modport source (output valid, output action, output frame_index, input ready);
   modport sink   (input valid, input action, input frame_index, output ready);
endinterface

// Response channel: status, granted frame and count after the operation
interface pfa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pfa_pkg::STATUS_W-1:0]    status;
   logic [pfa_pkg::FRAME_W-1:0]     granted_frame;
   logic [pfa_pkg::COUNT_OUT_W-1:0] count_after;

   modport source (output valid, output status, output granted_frame,
                   output count_after, input ready);
   modport sink   (input valid, input status, input granted_frame,
                   input count_after, output ready);
endinterface

[rtl/page_frame_allocator_refcount.sv]
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount: page-frame allocator with reference counts
// Keeps a used bit and a reference count per frame; allocates, adds and
// releases references one request at a time.
// ----------------------------------------------------------------------------
// Usage
// Requests enter on req_chan (action, frame_index) and each gives exactly one
// item on rsp_chan (status, granted_frame, count_after). The block takes one
// request at a time; req_chan.ready is high only while the sequencer is idle.
// Add and release pass through dispatch, update and hand-over to the output
// register; a new request is taken only after the hand-over. Allocate goes
// through dispatch, a pick of the highest word that is not full and an
// evaluation of that word; when the partly used top boundary word has no
// free frame inside the range, the scan passes it over and picks again. An
// empty range answers straight from dispatch. The summary vector of full
// words lets the scan skip every full word at once.
// The response sits in an output register: the next request is accepted while
// it waits, but the following response is held back until rsp_chan.ready.
// The user writes first_frame and end_frame on the csr_ port only while
// the block is idle; the block itself does not enforce this. After reset
// the block sweeps the count memory, one entry per cycle, BITMAP_WORDS*32
// entries capped at 1024, with ready low; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount #(
   parameter int BITMAP_WORDS = 32,
   parameter int COUNT_BITS   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   pfa_req_if.sink                       req_chan,
   pfa_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [pfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfa_pkg::CSR_W-1:0]     csr_wdata
);

   // Frames above 1023 cannot be addressed, so storage stops there
   localparam int WORDS  = (BITMAP_WORDS < 32) ? BITMAP_WORDS : 32;
   localparam int WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int FRAMES = WORDS * 32;
   localparam int FA     = $clog2(FRAMES);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DISP  = 3'd2;
   localparam logic [2:0] S_OOR   = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;
   localparam logic [2:0] S_PICK  = 3'd5;
   localparam logic [2:0] S_EVAL  = 3'd6;
   localparam logic [2:0] S_RESP  = 3'd7;

   logic [2:0]                        state_ff, state_in;
   logic [FA-1:0]                     clr_ff, clr_in;
   logic [pfa_pkg::CSR_W-1:0]         first_ff, first_in;
   logic [pfa_pkg::CSR_W-1:0]         end_ff, end_in;
   logic [pfa_pkg::CSR_W-1:0]         lim_ff, lim_in;
   logic [pfa_pkg::ACTION_W-1:0]      act_ff, act_in;
   logic [pfa_pkg::FRAME_W-1:0]       frame_ff, frame_in;
   logic [pfa_pkg::FRAME_W-1:0]       last_ff, last_in;
   logic [pfa_pkg::BIT_W-1:0]         cw_ff, cw_in;
   logic [pfa_pkg::BIT_W-1:0]         w_ff, w_in;
   logic [WORDS-1:0]                  full_ff, full_in;
   logic [pfa_pkg::STATUS_W-1:0]      res_status_ff, res_status_in;
   logic [pfa_pkg::FRAME_W-1:0]       res_frame_ff, res_frame_in;
   logic [pfa_pkg::COUNT_OUT_W-1:0]   res_count_ff, res_count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [pfa_pkg::FRAME_W-1:0]       rsp_frame_ff, rsp_frame_in;
   logic [pfa_pkg::COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                              cnt_we;
   logic [FA-1:0]                     cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0]             cnt_wdata, cnt_rdata;
   logic                              use_we;
   logic [WA-1:0]                     use_waddr, use_raddr;
   logic [pfa_pkg::WORD_W-1:0]        use_wdata, use_rdata;

   logic [pfa_pkg::WORD_W-1:0]        sum_vec;
   logic [pfa_pkg::WORD_W-1:0]        bit_mask;
   logic [pfa_pkg::WORD_W-1:0]        new_word;
   logic [COUNT_BITS-1:0]             new_count;
   logic [pfa_pkg::FRAME_W-1:0]       lim_m1;
   logic                              in_range;
   logic                              has_store;
   logic                              out_load;
   pfa_pkg::find_req_type             fq;
   pfa_pkg::find_res_type             fres;

   function automatic logic [pfa_pkg::COUNT_OUT_W-1:0] clamp_count(input logic [15:0] c);
      clamp_count = (c > 16'd255) ? 8'hFF : c[7:0];
   endfunction

   // Count and used-word memories
   pfa_ram #(.WIDTH(COUNT_BITS), .DEPTH(FRAMES)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   pfa_ram #(.WIDTH(pfa_pkg::WORD_W), .DEPTH(WORDS)) u_use_ram (
      .clock (clock),
      .we    (use_we),
      .waddr (use_waddr),
      .wdata (use_wdata),
      .raddr (use_raddr),
      .rdata (use_rdata)
   );

   // Summary vector: one bit per full word, missing words count as full
   for (genvar i = 0; i < pfa_pkg::WORD_W; i++) begin : g_sum
      if (i < WORDS) begin : g_word
         assign sum_vec[i] = full_ff[i];
      end else begin : g_pad
         assign sum_vec[i] = 1'b1;
      end
   end

   // The find unit serves the summary in PICK and the fetched word otherwise
   always_comb begin
      if (state_ff == S_PICK) begin
         fq.vec = sum_vec;
         fq.lo  = first_ff[9:5];
         fq.hi  = cw_ff;
      end else begin
         fq.vec = use_rdata;
         fq.lo  = (w_ff == first_ff[9:5]) ? first_ff[4:0] : '0;
         fq.hi  = (w_ff == last_ff[9:5]) ? last_ff[4:0] : '1;
      end
   end

   pfa_find u_find (
      .query  (fq),
      .answer (fres)
   );

   // Configuration registers and the effective frame limit
   always_comb begin
      first_in = first_ff;
      end_in   = end_ff;
      if (csr_we) begin
         unique case (csr_index)
            pfa_pkg::CSR_FIRST: first_in = csr_wdata;
            pfa_pkg::CSR_END:   end_in   = csr_wdata;
            default:            first_in = first_ff;
         endcase
      end
      lim_in = (end_in > pfa_pkg::CSR_W'(FRAMES)) ? pfa_pkg::CSR_W'(FRAMES) : end_in;
   end

   assign lim_m1    = pfa_pkg::FRAME_W'(lim_ff - 11'd1);
   assign in_range  = ({1'b0, frame_ff} >= first_ff) && ({1'b0, frame_ff} < lim_ff);
   assign has_store = {1'b0, frame_ff} < pfa_pkg::CSR_W'(FRAMES);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      act_in        = act_ff;
      frame_in      = frame_ff;
      last_in       = last_ff;
      cw_in         = cw_ff;
      w_in          = w_ff;
      full_in       = full_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_count_in  = res_count_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = frame_ff[FA-1:0];
      cnt_wdata     = '0;
      cnt_raddr     = frame_ff[FA-1:0];
      use_we        = 1'b0;
      use_waddr     = frame_ff[WA+4:5];
      use_wdata     = use_rdata;
      use_raddr     = frame_ff[WA+4:5];
      bit_mask      = pfa_pkg::WORD_W'(1) << frame_ff[4:0];
      new_word      = use_rdata;
      new_count     = cnt_rdata;

      unique case (state_ff)
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            use_we    = clr_ff < FA'(WORDS);
            use_waddr = clr_ff[WA-1:0];
            use_wdata = '0;
            if (clr_ff == FA'(FRAMES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               act_in   = req_chan.action;
               frame_in = req_chan.frame_index;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            // Reads for add, release and out-of-range go out here
            res_frame_in = frame_ff;
            if (act_ff == pfa_pkg::ACT_ALLOC) begin
               if (first_ff >= lim_ff) begin
                  res_status_in = pfa_pkg::ST_NOFREE;
                  res_frame_in  = '0;
                  res_count_in  = '0;
                  state_in      = S_RESP;
               end else begin
                  last_in  = lim_m1;
                  cw_in    = lim_m1[9:5];
                  state_in = S_PICK;
               end
            end else if ((act_ff == pfa_pkg::ACT_ADD || act_ff == pfa_pkg::ACT_REL)
                         && in_range) begin
               state_in = S_UPD;
            end else if (has_store) begin
               state_in = S_OOR;
            end else begin
               res_status_in = pfa_pkg::ST_RANGE;
               res_count_in  = '0;
               state_in      = S_RESP;
            end
         end
         S_OOR: begin
            res_status_in = pfa_pkg::ST_RANGE;
            res_count_in  = clamp_count(16'(cnt_rdata));
            state_in      = S_RESP;
         end
         S_UPD: begin
            // Read-modify-write of the count and the used word
            if (act_ff == pfa_pkg::ACT_ADD) begin
               new_word = use_rdata | bit_mask;
               if (cnt_rdata == CMAX) begin
                  new_count     = CMAX;
                  res_status_in = pfa_pkg::ST_SAT;
               end else begin
                  new_count     = cnt_rdata + 1'b1;
                  res_status_in = pfa_pkg::ST_OK;
               end
            end else begin
               if (cnt_rdata == '0) begin
                  new_count     = '0;
                  new_word      = use_rdata & ~bit_mask;
                  res_status_in = pfa_pkg::ST_FREE;
               end else begin
                  new_count     = cnt_rdata - 1'b1;
                  new_word      = (new_count == '0) ? (use_rdata & ~bit_mask) : use_rdata;
                  res_status_in = pfa_pkg::ST_OK;
               end
            end
            cnt_we    = 1'b1;
            cnt_wdata = new_count;
            use_we    = 1'b1;
            use_wdata = new_word;
            full_in[frame_ff[WA+4:5]] = &new_word;
            res_count_in = clamp_count(16'(new_count));
            state_in     = S_RESP;
         end
         S_PICK: begin
            // Highest word at or below the candidate that is not full
            if (fres.found) begin
               w_in      = fres.pos;
               use_raddr = fres.pos[WA-1:0];
               state_in  = S_EVAL;
            end else begin
               res_status_in = pfa_pkg::ST_NOFREE;
               res_frame_in  = '0;
               res_count_in  = '0;
               state_in      = S_RESP;
            end
         end
         S_EVAL: begin
            bit_mask = pfa_pkg::WORD_W'(1) << fres.pos;
            new_word = use_rdata | bit_mask;
            if (fres.found) begin
               use_we    = 1'b1;
               use_waddr = w_ff[WA-1:0];
               use_wdata = new_word;
               full_in[w_ff[WA-1:0]] = &new_word;
               cnt_we    = 1'b1;
               cnt_waddr = FA'({w_ff[WA-1:0], fres.pos});
               cnt_wdata = COUNT_BITS'(1);
               res_status_in = pfa_pkg::ST_OK;
               res_frame_in  = pfa_pkg::FRAME_W'({w_ff[WA-1:0], fres.pos});
               res_count_in  = pfa_pkg::COUNT_OUT_W'(1);
               state_in      = S_RESP;
            end else if (w_ff == first_ff[9:5]) begin
               res_status_in = pfa_pkg::ST_NOFREE;
               res_frame_in  = '0;
               res_count_in  = '0;
               state_in      = S_RESP;
            end else begin
               // Free bits lay outside the range; go on below this word
               cw_in    = w_ff - 1'b1;
               state_in = S_PICK;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loads when the previous item has left or is leaving
   assign out_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_count_in  = rsp_count_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_frame_in  = res_frame_ff;
         rsp_count_in  = res_count_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         first_ff     <= '0;
         end_ff       <= pfa_pkg::CSR_W'(1024);
         lim_ff       <= pfa_pkg::CSR_W'(FRAMES);
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         first_ff     <= first_in;
         end_ff       <= end_in;
         lim_ff       <= lim_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      frame_ff      <= frame_in;
      last_ff       <= last_in;
      cw_ff         <= cw_in;
      w_ff          <= w_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.granted_frame = rsp_frame_ff;
   assign rsp_chan.count_after   = rsp_count_ff;

endmodule

[rtl/pfa_ram.sv]
// ----------------------------------------------------------------------------
// pfa_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/pfa_find.sv]
// ----------------------------------------------------------------------------
// pfa_find: highest clear bit search
// Finds the highest-numbered zero bit of a 32-bit vector inside an inclusive
// window of positions. Shared by the summary search and the word search.
// ----------------------------------------------------------------------------
module pfa_find (
   input  pfa_pkg::find_req_type query,
   output pfa_pkg::find_res_type answer
);

   // Priority pick from the bottom up, so the highest candidate wins
   always_comb begin
      answer.found = 1'b0;
      answer.pos   = '0;
      for (int i = 0; i < pfa_pkg::WORD_W; i++) begin
         if (!query.vec[i] && (pfa_pkg::BIT_W'(i) >= query.lo)
             && (pfa_pkg::BIT_W'(i) <= query.hi)) begin
            answer.found = 1'b1;
            answer.pos   = pfa_pkg::BIT_W'(i);
         end
      end
   end

endmodule

[rtl/pfa_checker.sv]
// ----------------------------------------------------------------------------
// pfa_checker: port-level checks for the page-frame allocator
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module pfa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [pfa_pkg::STATUS_W-1:0]    rsp_status,
   input logic [pfa_pkg::FRAME_W-1:0]     rsp_granted_frame,
   input logic [pfa_pkg::COUNT_OUT_W-1:0] rsp_count_after
);

   logic [1:0] pend_ff, pend_in;

   // Items accepted whose response has not yet been taken
   always_comb begin
      pend_in = pend_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A waiting response stays offered until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

   // The sweep after reset keeps the request side closed
   a_reset_closed: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted straight after reset");

   // One request in work and one response waiting at most
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two items outstanding");

   // Every response belongs to an accepted item
   a_rsp_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without an accepted item");

   // A failed allocation grants nothing and reports a zero count
   a_nofree_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pfa_pkg::ST_NOFREE
      |-> rsp_granted_frame == '0 && rsp_count_after == '0)
      else $error("no-free response carries a frame or count");

endmodule

bind page_frame_allocator_refcount pfa_checker u_pfa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_granted_frame (rsp_chan.granted_frame),
   .rsp_count_after   (rsp_chan.count_after)
);

[sim/tb_page_frame_allocator_refcount.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_refcount: self-checking bench for the allocator
// Drives allocate, add, release and undefined requests through the request
// channel and keeps its own copy of the used bits, reference counts and
// range registers. Every response is checked against the predicted one, in
// order. The range is moved between phases, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_page_frame_allocator_refcount;

   localparam int NUM_FRAMES = 1024;
   localparam int COUNT_MAX = 255;
   localparam int STALL_LIMIT = 5000;
   localparam logic [pfa_pkg::ACTION_W-1:0] ACT_UNDEF = 2'd3;

   typedef struct packed {
      logic [pfa_pkg::ACTION_W-1:0] action;
      logic [pfa_pkg::FRAME_W-1:0]  frame;
   } frame_request_type;

   typedef struct packed {
      logic [pfa_pkg::STATUS_W-1:0]    status;
      logic [pfa_pkg::FRAME_W-1:0]     frame;
      logic [pfa_pkg::COUNT_OUT_W-1:0] count;
   } frame_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [pfa_pkg::CSR_IDX_W-1:0] csr_index;
   logic [pfa_pkg::CSR_W-1:0] csr_wdata;

   pfa_req_if req_chan ();
   pfa_rsp_if rsp_chan ();

   page_frame_allocator_refcount DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted allocator state and range registers.
   bit frame_used [0:NUM_FRAMES-1];
   logic [pfa_pkg::COUNT_OUT_W-1:0] frame_refs [0:NUM_FRAMES-1];
   logic [pfa_pkg::CSR_W-1:0] range_first;
   logic [pfa_pkg::CSR_W-1:0] range_end;

   frame_request_type pending_requests [$];
   frame_result_type expected_results [$];
   int send_idle_pct;
   int stall_pct;
   int error_count;
   int quiet_cycles;
   logic req_moved;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Applies one request to the predicted state and returns its response.
   function automatic frame_result_type apply_frame_request(frame_request_type req);
      frame_result_type res;
      int lim;
      int f;
      int g;
      bit hit;
      lim = (int'(range_end) > NUM_FRAMES) ? NUM_FRAMES : int'(range_end);
      f = int'(req.frame);
      res.status = pfa_pkg::ST_OK;
      res.frame = req.frame;
      res.count = '0;
      if (req.action == pfa_pkg::ACT_ALLOC) begin
         // Highest free frame in the managed range wins.
         hit = 1'b0;
         g = lim;
         while (g > int'(range_first) && !hit) begin
            g--;
            if (!frame_used[g]) hit = 1'b1;
         end
         if (hit) begin
            frame_used[g] = 1'b1;
            frame_refs[g] = pfa_pkg::COUNT_OUT_W'(1);
            res.frame = g[pfa_pkg::FRAME_W-1:0];
            res.count = pfa_pkg::COUNT_OUT_W'(1);
         end else begin
            res.status = pfa_pkg::ST_NOFREE;
            res.frame = '0;
         end
      end else if (req.action == ACT_UNDEF || f < int'(range_first) || f >= lim) begin
         res.status = pfa_pkg::ST_RANGE;
         res.count = frame_refs[f];
      end else if (req.action == pfa_pkg::ACT_ADD) begin
         frame_used[f] = 1'b1;
         if (int'(frame_refs[f]) >= COUNT_MAX) res.status = pfa_pkg::ST_SAT;
         else frame_refs[f] = frame_refs[f] + 1'b1;
         res.count = frame_refs[f];
      end else begin
         // Release: a count already at zero is reported, not wrapped.
         if (frame_refs[f] == '0) begin
            res.status = pfa_pkg::ST_FREE;
         end else begin
            frame_refs[f] = frame_refs[f] - 1'b1;
         end
         if (frame_refs[f] == '0) frame_used[f] = 1'b0;
         res.count = frame_refs[f];
      end
      return res;
   endfunction

   // Request driver: a new item is offered once the previous one has moved.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!req_chan.valid || req_moved) begin
            if (pending_requests.size() != 0
                && int'($urandom_range(99)) >= send_idle_pct) begin
               req_chan.valid <= 1'b1;
               req_chan.action <= pending_requests[0].action;
               req_chan.frame_index <= pending_requests[0].frame;
               void'(pending_requests.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= (int'($urandom_range(99)) >= stall_pct);
      end
   end

   // Monitor: checks responses, predicts accepted requests, guards progress.
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      frame_request_type req;
      if (reset) begin
         req_moved <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_moved <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.status = rsp_chan.status;
            got.frame = rsp_chan.granted_frame;
            got.count = rsp_chan.count_after;
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response: status %0d frame %0d count %0d",
                        $time, got.status, got.frame, got.count);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  error_count++;
                  $display("%0t: response mismatch: expected status %0d frame %0d count %0d,",
                           $time, want.status, want.frame, want.count);
                  $display("   actual status %0d frame %0d count %0d",
                           got.status, got.frame, got.count);
               end
            end
         end
         // A response never comes on the edge that accepts its own request.
         if (req_chan.valid && req_chan.ready) begin
            req.action = req_chan.action;
            req.frame = req_chan.frame_index;
            expected_results.push_back(apply_frame_request(req));
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_page_frame_allocator_refcount failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic write_reg(input logic [pfa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pfa_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == pfa_pkg::CSR_FIRST) range_first = value;
      else range_end = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_request(input logic [pfa_pkg::ACTION_W-1:0] action,
                                input logic [pfa_pkg::FRAME_W-1:0] frame);
      frame_request_type req;
      req.action = action;
      req.frame = frame;
      pending_requests.push_back(req);
   endtask

   // Waits until the block has answered everything sent to it.
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_chan.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Starts a phase: new range, new idling pattern.
   task automatic start_phase(input int first, input int last, input int send_pct,
                              input int stall);
      wait_idle();
      write_reg(pfa_pkg::CSR_FIRST, first[pfa_pkg::CSR_W-1:0]);
      write_reg(pfa_pkg::CSR_END, last[pfa_pkg::CSR_W-1:0]);
      send_idle_pct = send_pct;
      stall_pct = stall;
   endtask

   // Random mix; frames mostly fall in a window around the managed range.
   task automatic queue_random(input int n, input int lo, input int hi);
      int r;
      logic [pfa_pkg::ACTION_W-1:0] action;
      logic [pfa_pkg::FRAME_W-1:0] frame;
      for (int i = 0; i < n; i++) begin
         r = int'($urandom_range(99));
         if (r < 30) action = pfa_pkg::ACT_ALLOC;
         else if (r < 60) action = pfa_pkg::ACT_ADD;
         else if (r < 95) action = pfa_pkg::ACT_REL;
         else action = ACT_UNDEF;
         if ($urandom_range(9) == 0) begin
            frame = pfa_pkg::FRAME_W'($urandom_range(NUM_FRAMES - 1));
         end else begin
            frame = pfa_pkg::FRAME_W'($urandom_range(hi, lo));
         end
         queue_request(action, frame);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = pfa_pkg::CSR_FIRST;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.action = pfa_pkg::ACT_ALLOC;
      req_chan.frame_index = '0;
      rsp_chan.ready = 1'b0;
      req_moved = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      error_count = 0;
      quiet_cycles = 0;
      range_first = '0;
      range_end = pfa_pkg::CSR_W'(NUM_FRAMES);
      for (int i = 0; i < NUM_FRAMES; i++) begin
         frame_used[i] = 1'b0;
         frame_refs[i] = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full range: grants from the top, add, release, release of a free
      // frame and the undefined action.
      start_phase(0, NUM_FRAMES, 0, 0);
      queue_request(pfa_pkg::ACT_ALLOC, 10'd0);
      queue_request(pfa_pkg::ACT_ALLOC, 10'd1023);
      queue_request(pfa_pkg::ACT_ADD, 10'd1023);
      queue_request(pfa_pkg::ACT_ADD, 10'd0);
      queue_request(pfa_pkg::ACT_REL, 10'd0);
      queue_request(pfa_pkg::ACT_REL, 10'd0);
      queue_request(ACT_UNDEF, 10'd1023);
      queue_request(pfa_pkg::ACT_REL, 10'd1023);
      queue_request(pfa_pkg::ACT_REL, 10'd1023);
      queue_request(pfa_pkg::ACT_REL, 10'd1022);
      queue_request(pfa_pkg::ACT_ALLOC, 10'd512);

      // Two-frame range: exhaustion and frames on both sides of the range.
      start_phase(1020, 1022, 0, 0);
      queue_request(pfa_pkg::ACT_ALLOC, 10'd0);
      queue_request(pfa_pkg::ACT_ALLOC, 10'd1023);
      queue_request(pfa_pkg::ACT_ALLOC, 10'd0);
      queue_request(pfa_pkg::ACT_ADD, 10'd1019);
      queue_request(pfa_pkg::ACT_ADD, 10'd1022);
      queue_request(pfa_pkg::ACT_ADD, 10'd1023);
      queue_request(pfa_pkg::ACT_REL, 10'd1021);
      queue_request(pfa_pkg::ACT_ALLOC, 10'd0);

      // Empty range.
      start_phase(NUM_FRAMES, NUM_FRAMES, 0, 0);
      queue_request(pfa_pkg::ACT_ALLOC, 10'd0);
      queue_request(pfa_pkg::ACT_REL, 10'd0);

      start_phase(0, NUM_FRAMES, 0, 0);
      queue_random(200, 960, 1023);

      start_phase(1000, 1010, 80, 0);
      queue_random(200, 996, 1013);

      // Drive one frame into saturation, then mix around it.
      start_phase(5, 7, 0, 80);
      for (int i = 0; i < 270; i++) queue_request(pfa_pkg::ACT_ADD, 10'd6);
      queue_random(100, 3, 8);

      start_phase(NUM_FRAMES, 0, 21, 21);
      queue_random(40, 0, NUM_FRAMES - 1);

      start_phase(0, 40, 0, 0);
      queue_random(250, 0, 41);

      start_phase(900, NUM_FRAMES, 80, 0);
      queue_random(200, 890, 1023);

      start_phase(512, 544, 21, 21);
      queue_random(80, 508, 547);

      wait_idle();
      repeat (20) @(posedge clock);
      if (expected_results.size() != 0) begin
         error_count++;
         $display("%0t: %0d responses never arrived", $time, expected_results.size());
      end
      if (error_count == 0) begin
         $display("tb_page_frame_allocator_refcount passed");
      end else begin
         $display("tb_page_frame_allocator_refcount failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/pfa_pkg.sv
rtl/pfa_if.sv
rtl/pfa_ram.sv
rtl/pfa_find.sv
rtl/page_frame_allocator_refcount.sv
rtl/pfa_checker.sv
sim/tb_page_frame_allocator_refcount.sv
